// ===== sv/tsl_pkg.sv =====
package tsl_pkg;

	// run table geometry
	localparam int unsigned MAX_ENTRIES = 1024;
	localparam int ADDR_W = $clog2(MAX_ENTRIES);

	// field widths
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int WORD_W = 32;
	localparam int TIME_W = 64;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int REG_SEL_W = PADDR_W - 2;
	localparam logic [REG_SEL_W-1:0] REG_TABLE_PRESENT = 1'b0;
	localparam logic [REG_SEL_W-1:0] REG_ENTRY_COUNT   = 1'b1;

	// item operations
	localparam logic OP_FIND = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// result status
	localparam logic ST_OK           = 1'b0;
	localparam logic ST_INVALID_FILE = 1'b1;

	typedef struct packed {
		logic              table_present;
		logic [CNT_W-1:0]  entry_count;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] delta;
		logic [WORD_W-1:0] count;
	} run_t;

endpackage

// ===== sv/tsl_regs.sv =====
module tsl_regs import tsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic                 wr_en;
	logic [REG_SEL_W-1:0] reg_sel;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TABLE_PRESENT: cfg_q.table_present <= pwdata[0];
				REG_ENTRY_COUNT:   cfg_q.entry_count   <= pwdata[CNT_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_TABLE_PRESENT: prdata = WORD_W'(cfg_q.table_present);
			REG_ENTRY_COUNT:   prdata = WORD_W'(cfg_q.entry_count);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/tsl_run_ram.sv =====
module tsl_run_ram import tsl_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  run_t              wdata,
	input  logic [ADDR_W-1:0] raddr,
	output run_t              rdata
);

	run_t mem [MAX_ENTRIES];
	run_t rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tsl_div.sv =====
module tsl_div import tsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend_hi,
	input  logic [WORD_W-1:0] dividend_lo,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient,
	output logic [WORD_W-1:0] remainder
);

	localparam int STEP_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;

	logic [WORD_W:0]   shifted_w;
	logic [WORD_W:0]   diff_w;
	logic              take_w;

	// restoring division, one quotient bit a cycle; dividend_hi < divisor
	assign shifted_w = {rem_q, quo_q[WORD_W-1]};
	assign diff_w    = shifted_w - {1'b0, dvs_q};
	assign take_w    = (shifted_w >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi;
			quo_q <= dividend_lo;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take_w ? diff_w[WORD_W-1:0] : shifted_w[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], take_w};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== sv/time_to_sample_lookup_top.sv =====
// channel   direction  handshake                 payload
// config    in         psel/penable/pwrite       paddr, pwdata (prdata back, pready tied high)
// item in   in         in_valid / in_stall       operation, entry_index, sample_count,
//                                                sample_delta, target_time
// item out  out        out_valid / out_stall     status, sample_number, prev_sample_number
//
// a load item is taken at its accept edge, which writes the run and clears the cache
// find walk: no table goes straight to the output; else per run the check, read and evaluate
// states, the divider when a run needs it, then advance; past the last run, a check then output
// reset clears the cache, the config registers and out_valid; the run memory is not cleared, no sweep
// a finished result waits in the output register while loads and a new find are taken;
// a second result waits inside until the first has gone
module time_to_sample_lookup_top import tsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0]  pwdata,
	output logic [WORD_W-1:0]  prdata,
	output logic               pready,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [IDX_W-1:0]   entry_index,
	input  logic [WORD_W-1:0]  sample_count,
	input  logic [WORD_W-1:0]  sample_delta,
	input  logic [TIME_W-1:0]  target_time,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [WORD_W-1:0]  sample_number,
	output logic [WORD_W-1:0]  prev_sample_number
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an item
	localparam logic [2:0] S_CHK  = 3'd1;   // end of table check, run read issued
	localparam logic [2:0] S_RD   = 3'd2;   // run data back from memory
	localparam logic [2:0] S_EVAL = 3'd3;   // classify the run, start division
	localparam logic [2:0] S_DIV  = 3'd4;   // step count within the run
	localparam logic [2:0] S_ADV  = 3'd5;   // pass over the whole run
	localparam logic [2:0] S_OUT  = 3'd6;   // hand result to output register

	cfg_t cfg;

	logic [2:0]        state_q;

	// search cache, which is also the walk position
	logic [CNT_W-1:0]  ci_q;
	logic [TIME_W-1:0] ct_q;
	logic [WORD_W-1:0] cfs_q;

	// per-find working registers
	logic [TIME_W-1:0] target_q;
	logic [WORD_W-1:0] cnt_q;
	logic [WORD_W-1:0] dlt_q;
	logic [TIME_W-1:0] n1_q;
	logic              t_ge_q;
	logic              t_eq_q;
	logic [TIME_W-1:0] span_q;

	// pending result and output register
	logic              res_status_q;
	logic [WORD_W-1:0] res_samp_q;
	logic [WORD_W-1:0] res_prev_q;
	logic              out_valid_q;
	logic              status_q;
	logic [WORD_W-1:0] samp_out_q;
	logic [WORD_W-1:0] prev_out_q;

	logic              in_accept;
	logic              load_acc;
	logic              find_acc;
	logic              out_free;
	logic [CNT_W-1:0]  limit_w;
	logic              ram_we;
	run_t              ram_wdata;
	run_t              ram_rdata;
	logic [TIME_W-1:0] span_w;

	logic              div_start;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;
	logic [WORD_W-1:0] div_rem;

	logic [WORD_W:0]   step_w;
	logic              fits_w;
	logic [WORD_W-1:0] gap_w;
	logic [TIME_W:0]   reach_w;
	logic              div_hit_w;
	logic              eval_hit_w;
	logic [WORD_W-1:0] hit_base_w;
	logic              hit_exact_w;

	tsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// loads land only in idle, so no read meets a write; user writes config only in idle, unenforced
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign load_acc  = in_accept && (operation == OP_LOAD);
	assign find_acc  = in_accept && (operation == OP_FIND);
	assign out_free  = !out_valid_q || !out_stall;

	// runs walked: the smaller of entry_count and the memory depth
	assign limit_w = (32'(cfg.entry_count) < MAX_ENTRIES) ? cfg.entry_count
	                                                        : CNT_W'(MAX_ENTRIES);

	assign ram_we    = load_acc && (32'(entry_index) < MAX_ENTRIES);
	assign ram_wdata = '{delta: sample_delta, count: sample_count};

	tsl_run_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(entry_index)),
		.wdata (ram_wdata),
		.raddr (ADDR_W'(ci_q)),
		.rdata (ram_rdata)
	);

	// whole-run time span, registered before the cache add
	assign span_w = {{(TIME_W-WORD_W){1'b0}}, cnt_q} * {{(TIME_W-WORD_W){1'b0}}, dlt_q};

	// target strictly ahead of the run start with a nonzero delta: the step count is
	// ceil((target - t) / delta), i.e. (target - t - 1) / delta + 1; when the high word
	// already reaches the delta the count is beyond any 32-bit run
	assign eval_hit_w = (cnt_q != '0) && t_ge_q;
	assign div_start  = (state_q == S_EVAL) && (cnt_q != '0) && !t_ge_q &&
	                    (dlt_q != '0) && (n1_q[TIME_W-1:WORD_W] < dlt_q);

	tsl_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (div_start),
		.dividend_hi (n1_q[TIME_W-1:WORD_W]),
		.dividend_lo (n1_q[WORD_W-1:0]),
		.divisor     (dlt_q),
		.done        (div_done),
		.quotient    (div_quo),
		.remainder   (div_rem)
	);

	// the reached time is target + (delta - 1 - rem); a carry out means the time wrapped
	// before the target, and after a wrap no later step of the run can reach it
	assign step_w    = {1'b0, div_quo} + (WORD_W+1)'(1);
	assign fits_w    = (step_w < {1'b0, cnt_q});
	assign gap_w     = dlt_q - WORD_W'(1) - div_rem;
	assign reach_w   = {1'b0, target_q} + (TIME_W+1)'(gap_w);
	assign div_hit_w = fits_w && !reach_w[TIME_W];

	// base is the hit sample number minus one
	always_comb begin
		if (state_q == S_DIV) begin
			hit_base_w  = cfs_q + div_quo;
			hit_exact_w = (div_rem == (dlt_q - WORD_W'(1)));
		end else begin
			hit_base_w  = cfs_q - WORD_W'(1);
			hit_exact_w = t_eq_q;
		end
	end

	// sequencer and cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ci_q        <= '0;
			ct_q        <= '0;
			cfs_q       <= '0;
		end else begin
			// a new result replaces the one taken at this edge
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_acc) begin
						// a load invalidates the cache
						ci_q  <= '0;
						ct_q  <= '0;
						cfs_q <= '0;
					end else if (find_acc) begin
						if (!cfg.table_present) begin
							state_q <= S_OUT;
						end else begin
							// restart from the first run when the cache is unusable
							if (cfs_q == '0 || target_time < ct_q) begin
								ci_q  <= '0;
								ct_q  <= '0;
								cfs_q <= WORD_W'(1);
							end
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					state_q <= (ci_q >= limit_w) ? S_OUT : S_RD;
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					priority if (cnt_q == '0) begin
						state_q <= S_ADV;
					end else if (t_ge_q) begin
						state_q <= S_OUT;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= div_hit_w ? S_OUT : S_ADV;
					end
				end
				S_ADV: begin
					ct_q    <= ct_q + span_q;
					cfs_q   <= cfs_q + cnt_q;
					ci_q    <= ci_q + CNT_W'(1);
					state_q <= S_CHK;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (find_acc) begin
					target_q     <= target_time;
					res_status_q <= cfg.table_present ? ST_OK : ST_INVALID_FILE;
					res_samp_q   <= '0;
					res_prev_q   <= '0;
				end
			end
			S_RD: begin
				cnt_q  <= ram_rdata.count;
				dlt_q  <= ram_rdata.delta;
				n1_q   <= target_q - ct_q - TIME_W'(1);
				t_ge_q <= (ct_q >= target_q);
				t_eq_q <= (ct_q == target_q);
			end
			S_EVAL: begin
				span_q <= span_w;
				if (eval_hit_w) begin
					res_samp_q <= hit_exact_w ? hit_base_w + WORD_W'(1) : '0;
					res_prev_q <= hit_exact_w ? '0 :
					              ((hit_base_w == '0) ? WORD_W'(1) : hit_base_w);
				end
			end
			S_DIV: begin
				if (div_done && div_hit_w) begin
					res_samp_q <= hit_exact_w ? hit_base_w + WORD_W'(1) : '0;
					res_prev_q <= hit_exact_w ? '0 :
					              ((hit_base_w == '0) ? WORD_W'(1) : hit_base_w);
				end
			end
			S_OUT: begin
				if (out_free) begin
					status_q   <= res_status_q;
					samp_out_q <= res_samp_q;
					prev_out_q <= res_prev_q;
				end
			end
			S_CHK, S_ADV: begin
				target_q <= target_q;
			end
			default: begin
				target_q <= target_q;
			end
		endcase
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign sample_number      = samp_out_q;
	assign prev_sample_number = prev_out_q;

endmodule

// ===== sv/tsl_checker.sv =====
module tsl_checker import tsl_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               operation,
	input logic               out_valid,
	input logic               out_stall,
	input logic               status,
	input logic [WORD_W-1:0]  sample_number,
	input logic [WORD_W-1:0]  prev_sample_number
);

	// a held result keeps its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(sample_number) && $stable(prev_sample_number))
		else $error("result changed while stalled");

	// exact hit and near hit never both reported
	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_number == '0) || (prev_sample_number == '0))
		else $error("both sample fields nonzero");

	// absent table gives no sample
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INVALID_FILE) |->
		(sample_number == '0) && (prev_sample_number == '0))
		else $error("sample reported with error status");

	// a load item produces no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_LOAD) && !out_valid |=> !out_valid)
		else $error("result after load item");

endmodule

bind time_to_sample_lookup_top tsl_checker u_tsl_checker (.*);

// ===== dv/time_to_sample_lookup_top_tb.sv =====
`timescale 1ns / 1ps

module time_to_sample_lookup_top_tb;
	import tsl_pkg::*;

	// cycles with no item, result or register write before the run is abandoned
	localparam int QUIET_LIMIT = 200000;
	// random items wanted after the directed part and the bulk table fill,
	// which between them already send about 1040 items
	localparam int RANDOM_ITEMS = 340;

	// one item as it goes onto the input channel
	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   slot;
		logic [WORD_W-1:0]  cnt;
		logic [WORD_W-1:0]  dlt;
		logic [TIME_W-1:0]  tgt;
	} lookup_item_t;

	// one expected find result
	typedef struct packed {
		logic               status;
		logic [WORD_W-1:0]  sample_no;
		logic [WORD_W-1:0]  prev_no;
	} lookup_t;

	logic               clk;
	logic               arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [WORD_W-1:0]  pwdata = '0;
	logic [WORD_W-1:0]  prdata;
	logic               pready;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = OP_FIND;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [WORD_W-1:0]  sample_count = '0;
	logic [WORD_W-1:0]  sample_delta = '0;
	logic [TIME_W-1:0]  target_time = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               status;
	logic [WORD_W-1:0]  sample_number;
	logic [WORD_W-1:0]  prev_sample_number;

	// items waiting for the driver, and find results still owed by the block
	lookup_item_t pending_items[$];
	lookup_t      lookups_due[$];
	lookup_item_t next_item;
	lookup_t      due_result;
	lookup_t      want;

	// no idling on either side while set
	logic steady = 1'b0;

	// predictor copy of the run table, the search cache and the registers
	logic [WORD_W-1:0] run_cnt [MAX_ENTRIES];
	logic [WORD_W-1:0] run_dlt [MAX_ENTRIES];
	logic [WORD_W-1:0] cache_run = '0;
	logic [TIME_W-1:0] cache_time = '0;
	logic [WORD_W-1:0] cache_first = '0;
	logic              cfg_present = 1'b0;
	logic [CNT_W-1:0]  cfg_count = '0;

	// stimulus-side copy of the table, ahead of the predictor by the queued loads
	logic [WORD_W-1:0] plan_cnt [MAX_ENTRIES];
	logic [WORD_W-1:0] plan_dlt [MAX_ENTRIES];
	logic              plan_present = 1'b0;
	logic [CNT_W-1:0]  plan_count = '0;

	int errors = 0;
	int checked = 0;
	int n_loads = 0;
	int n_finds = 0;
	int n_exact = 0;
	int n_near = 0;
	int n_off_end = 0;
	int n_absent = 0;
	int phases = 0;
	int quiet = 0;

	time_to_sample_lookup_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.entry_index(entry_index),
		.sample_count(sample_count),
		.sample_delta(sample_delta),
		.target_time(target_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.sample_number(sample_number),
		.prev_sample_number(prev_sample_number)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// does a run starting at time start reach the target? steps gives the first
	// step whose wrapped time is at or past the target
	function automatic bit run_reaches(input logic [TIME_W-1:0] start,
			input logic [WORD_W-1:0] rc, input logic [WORD_W-1:0] rd,
			input logic [TIME_W-1:0] tgt, output logic [TIME_W-1:0] steps);
		logic [TIME_W-1:0] j, cur, remain, k, room, q;
		j = '0;
		cur = start;
		steps = '0;
		while (j < {32'd0, rc}) begin
			remain = {32'd0, rc} - j;
			if (cur >= tgt) begin
				steps = j;
				return 1'b1;
			end
			if (rd == '0)
				return 1'b0;
			k = (tgt - cur - 64'd1) / {32'd0, rd} + 64'd1;
			room = 64'hFFFF_FFFF_FFFF_FFFF - cur;
			q = room / {32'd0, rd};
			if (k <= q) begin
				if (k >= remain)
					return 1'b0;
				steps = j + k;
				return 1'b1;
			end
			// the step after q carries the time past 2^64
			if (q + 64'd1 >= remain)
				return 1'b0;
			j = j + q + 64'd1;
			cur = cur + (q + 64'd1) * {32'd0, rd};
		end
		return 1'b0;
	endfunction

	// walk the runs for one find, moving the cache past every run passed in full
	function automatic void lookup_sample(input logic [TIME_W-1:0] tgt, output lookup_t r);
		logic [WORD_W-1:0] run, lim, samp, rc, rd;
		logic [TIME_W-1:0] t, steps, hit, span;
		bit found;
		r = '0;
		if (cfg_present == 1'b0) begin
			r.status = ST_INVALID_FILE;
			n_absent++;
			return;
		end
		r.status = ST_OK;
		if (cache_first != '0 && tgt >= cache_time) begin
			run = cache_run;
			t = cache_time;
			samp = cache_first;
		end else begin
			run = '0;
			t = '0;
			samp = 32'd1;
			cache_run = '0;
			cache_time = '0;
			cache_first = 32'd1;
		end
		lim = ({21'd0, cfg_count} < MAX_ENTRIES) ? {21'd0, cfg_count} : MAX_ENTRIES;
		found = 1'b0;
		while (!found && run < lim) begin
			rc = run_cnt[run];
			rd = run_dlt[run];
			if (run_reaches(t, rc, rd, tgt, steps)) begin
				found = 1'b1;
				hit = t + steps * {32'd0, rd};
				samp = samp + steps[WORD_W-1:0];
				if (hit == tgt) begin
					r.sample_no = samp;
					n_exact++;
				end else begin
					// a near hit on the very first sample still reports sample 1
					r.prev_no = (samp != 32'd1) ? samp - 32'd1 : 32'd1;
					n_near++;
				end
			end else begin
				span = {32'd0, rc} * {32'd0, rd};
				t = t + span;
				samp = samp + rc;
				cache_time = cache_time + span;
				cache_run = cache_run + 32'd1;
				cache_first = cache_first + rc;
				run = run + 32'd1;
			end
		end
		if (!found)
			n_off_end++;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic int unsigned plan_lim();
		return ({21'd0, plan_count} < MAX_ENTRIES) ? {21'd0, plan_count} : MAX_ENTRIES;
	endfunction

	// start time of a run, wrapped to 64 bits
	function automatic logic [TIME_W-1:0] run_start(input int unsigned idx);
		logic [TIME_W-1:0] acc;
		int unsigned k;
		acc = '0;
		for (k = 0; k < idx; k++)
			acc = acc + {32'd0, plan_cnt[k]} * {32'd0, plan_dlt[k]};
		return acc;
	endfunction

	// the time of some sample inside a run, now and then nudged off it
	function automatic logic [TIME_W-1:0] pick_time(input int unsigned idx);
		logic [TIME_W-1:0] t;
		logic [WORD_W-1:0] c, j;
		c = plan_cnt[idx];
		t = run_start(idx);
		if (c == '0)
			j = '0;
		else if (c > 32'd8 && $urandom_range(0, 1) != 0)
			j = ($urandom_range(0, 1) != 0) ? c - 32'd1 : $urandom_range(0, 3);
		else
			j = $urandom_range(0, c - 32'd1);
		t = t + {32'd0, j} * {32'd0, plan_dlt[idx]};
		case ($urandom_range(0, 9))
			6, 7: t = t + 64'd1;
			8: t = t - 64'd1;
			9: t = t + {33'd0, plan_dlt[idx][WORD_W-1:1]};
			default: ;
		endcase
		return t;
	endfunction

	function automatic logic [TIME_W-1:0] odd_target();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return run_start(plan_lim());
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// half of them short gentle runs, the rest empty runs, zero steps and huge values
	function automatic run_t random_run();
		run_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			r.count = $urandom_range(1, 6);
			r.delta = $urandom_range(1, 30);
		end else if (pick < 58) begin
			r.count = '0;
			r.delta = $urandom;
		end else if (pick < 68) begin
			r.count = $urandom_range(1, 5);
			r.delta = '0;
		end else if (pick < 82) begin
			r.count = $urandom;
			r.delta = $urandom;
		end else if (pick < 91) begin
			r.count = $urandom_range(1, 4);
			r.delta = 32'hFFFF_FFFF - $urandom_range(0, 15);
		end else begin
			r.count = 32'hFFFF_FFFF - $urandom_range(0, 15);
			r.delta = $urandom_range(1, 3);
		end
		return r;
	endfunction

	function automatic void queue_find(input logic [TIME_W-1:0] tgt);
		lookup_item_t it;
		it.op = OP_FIND;
		it.slot = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));
		it.cnt = $urandom;
		it.dlt = $urandom;
		it.tgt = tgt;
		pending_items.push_back(it);
	endfunction

	function automatic void queue_load(input int unsigned slot, input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] d);
		lookup_item_t it;
		it.op = OP_LOAD;
		it.slot = IDX_W'(slot);
		it.cnt = c;
		it.dlt = d;
		it.tgt = {$urandom, $urandom};
		pending_items.push_back(it);
		plan_cnt[slot] = c;
		plan_dlt[slot] = d;
	endfunction

	// a handful of finds walking forward through the table, so the cache gets reused
	function automatic int queue_burst();
		int unsigned lim, run, n, k;
		lim = plan_lim();
		if (!plan_present || lim == 0) begin
			queue_find(odd_target());
			return 1;
		end
		run = $urandom_range(0, lim - 1);
		n = $urandom_range(2, 6);
		for (k = 0; k < n; k++) begin
			if (run >= lim) begin
				queue_find(run_start(lim) + TIME_W'($urandom_range(0, 3)));
				return k + 1;
			end
			queue_find(pick_time(run));
			run = run + $urandom_range(0, 2);
		end
		return n;
	endfunction

	// wait until every item has gone in and every result has come out
	task automatic settle();
		while (pending_items.size() != 0 || in_valid || lookups_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// setup cycle then access cycle; the register takes the value at the access edge
	task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [WORD_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_TABLE_PRESENT) begin
			cfg_present = value[0];
			plan_present = value[0];
		end else begin
			cfg_count = value[CNT_W-1:0];
			plan_count = value[CNT_W-1:0];
		end
	endtask

	// ------------------------------------------------------------------
	// driver: presents queued items, runs the predictor on every accepted one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (operation == OP_LOAD) begin
					// a load writes its run and always clears the cache
					run_cnt[entry_index] = sample_count;
					run_dlt[entry_index] = sample_delta;
					cache_run = '0;
					cache_time = '0;
					cache_first = '0;
					n_loads++;
				end else begin
					lookup_sample(target_time, due_result);
					lookups_due.push_back(due_result);
					n_finds++;
				end
			end
			// a held item stays put until taken
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 13)) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					operation <= next_item.op;
					entry_index <= next_item.slot;
					sample_count <= next_item.cnt;
					sample_delta <= next_item.dlt;
					target_time <= next_item.tgt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: random back-pressure, each result checked against the oldest due
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookups_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status %0d sample %0d prev %0d",
							status, sample_number, prev_sample_number);
				end else begin
					want = lookups_due.pop_front();
					checked++;
					if (status !== want.status || sample_number !== want.sample_no
							|| prev_sample_number !== want.prev_no) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: expected status %0d sample %0d prev %0d, %s %0d %0d %0d",
								checked, want.status, want.sample_no, want.prev_no,
								"got", status, sample_number, prev_sample_number);
					end
				end
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 13);
		end
	end

	// watchdog: a long quiet spell means the block has hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned rand_items, n, sel, phase_len, slot, lim;
		logic [CNT_W-1:0] count;
		logic present;
		run_t r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		@(posedge clk);

		// no table yet: finds report an invalid file
		queue_find('0);
		queue_find('1);
		settle();

		// table present but empty: every find runs off the end
		write_reg(REG_TABLE_PRESENT, 32'd1);
		write_reg(REG_ENTRY_COUNT, 32'd0);
		queue_find('0);
		queue_find(64'd77);

		// small hand-built table: an empty run, a zero-step run and huge runs
		queue_load(0, 32'd3, 32'd10);
		queue_load(1, 32'd0, 32'd5);
		queue_load(2, 32'd2, 32'd0);
		queue_load(3, 32'd4, 32'd7);
		queue_load(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_load(5, 32'hFFFF_FFFF, 32'd1);
		queue_load(MAX_ENTRIES - 1, 32'hFFFF_FFFF, 32'd0);
		settle();
		write_reg(REG_ENTRY_COUNT, 32'd6);

		// exact hit on sample 1, near hit on sample 1, exact hit further in
		queue_find(64'd0);
		queue_find(64'd5);
		queue_find(64'd10);
		// resumed from the cache: past the empty run into the zero-step one
		queue_find(64'd25);
		queue_find(64'd30);
		queue_find(64'd31);
		// earlier than the cache, so the walk restarts
		queue_find(64'd12);
		// deep targets through the wrapping runs
		queue_find('1);
		queue_find(64'h8000_0000_0000_0000);
		queue_find(64'hFFFF_FFFF_FFFF_FFF0);
		settle();

		// fill every remaining slot so no find can ever read an unwritten run
		for (slot = 6; slot < MAX_ENTRIES; slot++) begin
			r = random_run();
			queue_load(slot, r.count, r.delta);
		end
		settle();
		write_reg(REG_ENTRY_COUNT, MAX_ENTRIES);
		queue_find('1);
		queue_find('0);
		queue_find(pick_time(MAX_ENTRIES - 1));
		queue_find(pick_time(MAX_ENTRIES / 2));
		settle();

		// random settings, each followed by a mix of find bursts, loads and odd finds;
		// the first one runs without any idling on either side
		rand_items = 0;
		steady <= 1'b1;
		while (rand_items < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (phases == 0 || sel >= 26)
				count = CNT_W'($urandom_range(2, 24));
			else if (sel < 8)
				count = '0;
			else if (sel < 16)
				count = 11'd1;
			else if (sel < 22)
				count = CNT_W'(MAX_ENTRIES);
			else
				count = CNT_W'($urandom_range(100, MAX_ENTRIES - 1));
			present = ($urandom_range(0, 99) < 88);
			write_reg(REG_TABLE_PRESENT, {31'd0, present});
			write_reg(REG_ENTRY_COUNT, {21'd0, count});

			// big tables make every find slow, so keep those settings short
			phase_len = (count > 64) ? 12 : 40;
			n = 0;
			while (n < phase_len) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					n = n + queue_burst();
				end else if (sel < 82) begin
					lim = plan_lim();
					if (lim != 0 && $urandom_range(0, 99) < 80)
						slot = $urandom_range(0, lim - 1);
					else
						slot = $urandom_range(0, MAX_ENTRIES - 1);
					r = random_run();
					queue_load(slot, r.count, r.delta);
					n++;
				end else begin
					queue_find(odd_target());
					n++;
				end
			end
			rand_items = rand_items + n;
			phases++;
			settle();
			steady <= 1'b0;
		end

		repeat (64) @(posedge clk);
		errors = errors + lookups_due.size();

		$display("covered %0d load items and %0d find items, %0d random settings after %s",
			n_loads, n_finds, phases, "the directed and full-table checks");
		$display("finds: %0d exact, %0d between samples, %0d past the end, %0d no table; %0d checked",
			n_exact, n_near, n_off_end, n_absent, checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
